/* hw/rtl/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, constants and the control program of the envelope sequencer.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEN_W   = 16;
    localparam int LVL_W   = 12;
    localparam int STAGE_W = 3;
    localparam int PROD_W  = LEN_W + LVL_W;
    localparam int CNT_W   = 4;
    localparam int STEP_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] MAX_STAGE_TICKS = 16'd60000;
    localparam logic [LVL_W-1:0] OUT_MAX         = 12'd4095;
    localparam logic [CNT_W-1:0] DIV_LAST        = 4'd11;

    // reset values of the configuration registers
    localparam logic [LEN_W-1:0] ATTACK_RST  = 16'd6000;
    localparam logic [LEN_W-1:0] DECAY_RST   = 16'd6000;
    localparam logic [LVL_W-1:0] SUSTAIN_RST = 12'd2047;
    localparam logic [LEN_W-1:0] RELEASE_RST = 16'd6000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

    // envelope stages
    localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

    // program steps
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SETUP  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_INIT   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIV    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd4;

    // datapath operations
    localparam logic [2:0] OP_ACCEPT   = 3'd0;
    localparam logic [2:0] OP_SETUP    = 3'd1;
    localparam logic [2:0] OP_DIV_INIT = 3'd2;
    localparam logic [2:0] OP_DIV_STEP = 3'd3;
    localparam logic [2:0] OP_COMMIT   = 3'd4;

    // jump conditions
    localparam logic [2:0] COND_NO_IN    = 3'd0;
    localparam logic [2:0] COND_DIRECT   = 3'd1;
    localparam logic [2:0] COND_ALWAYS   = 3'd2;
    localparam logic [2:0] COND_CNT_NZ   = 3'd3;
    localparam logic [2:0] COND_OUT_BUSY = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } uc_word_t;

    function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
        uc_word_t w;
        case (step)
            STEP_IDLE:   w = '{OP_ACCEPT,   COND_NO_IN,    STEP_IDLE,   STEP_SETUP};
            STEP_SETUP:  w = '{OP_SETUP,    COND_DIRECT,   STEP_COMMIT, STEP_INIT};
            STEP_INIT:   w = '{OP_DIV_INIT, COND_ALWAYS,   STEP_DIV,    STEP_DIV};
            STEP_DIV:    w = '{OP_DIV_STEP, COND_CNT_NZ,   STEP_DIV,    STEP_COMMIT};
            STEP_COMMIT: w = '{OP_COMMIT,   COND_OUT_BUSY, STEP_COMMIT, STEP_IDLE};
            default:     w = '{OP_COMMIT,   COND_ALWAYS,   STEP_IDLE,   STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (v > MAX_STAGE_TICKS) ? MAX_STAGE_TICKS : v;
    endfunction

endpackage

/* hw/rtl/adsr_envelope_generator.sv */
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope, one level and stage per gate tick, run by a
// microcoded sequencer over a multiplier and a shift-subtract divider.
// ----------------------------------------------------------------------------
// a tick runs through accept, setup, divider load, 12 quotient bits and commit
//   when a division is needed, and through accept, setup and commit otherwise
// a tick is taken only once the last one is committed, so the 12-step divider
//   loop sets the tick rate; the next tick is taken while the result waits
// reset: stage idle, gate low, counter zero, registers at their defaults
module adsr_envelope_generator
    import adsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  gate,
    // envelope output
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LVL_W-1:0]      level,
    output logic [STAGE_W-1:0]    phase
);

    // configuration registers
    logic [LEN_W-1:0] attack_reg;
    logic [LEN_W-1:0] decay_reg;
    logic [LVL_W-1:0] sustain_reg;
    logic [LEN_W-1:0] release_reg;

    // envelope state
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic               gate_prev_reg, gate_prev_next;
    logic [LEN_W-1:0]   tick_reg, tick_next;

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    uc_word_t          uc;
    logic              cond_hit;

    // datapath
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [LEN_W-1:0]  div_reg, div_next;      // divisor, also the stage length
    logic [LVL_W-1:0]  base_reg, base_next;    // constant level or decay offset
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LVL_W-1:0]  num_reg, num_next;      // low dividend bits, shifted out
    logic [LVL_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [STAGE_W-1:0] phase_reg, phase_next;

    // setup decode
    logic [LEN_W-1:0] len_sel;
    logic [LEN_W-1:0] remain;
    logic [LEN_W-1:0] mul_a;
    logic [LVL_W-1:0] mul_b;
    logic [LVL_W-1:0] offset;
    logic [LVL_W-1:0] direct_val;
    logic             direct;

    // divider step
    logic [LEN_W:0] trial;
    logic [LEN_W:0] diff;
    logic           qbit;

    logic in_xfer;
    logic out_free;
    logic [STAGE_W-1:0] stage_eff;

    assign in_ready  = (step_reg == STEP_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign phase     = phase_reg;

    // configuration port, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RST;
            decay_reg   <= DECAY_RST;
            sustain_reg <= SUSTAIN_RST;
            release_reg <= RELEASE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_data;
                REG_DECAY:   decay_reg   <= cfg_data;
                REG_SUSTAIN: sustain_reg <= cfg_data[LVL_W-1:0];
                REG_RELEASE: release_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // control word fetch and branch
    assign uc = uc_rom(step_reg);

    always_comb
    begin
        case (uc.cond)
            COND_NO_IN:    cond_hit = !in_xfer;
            COND_DIRECT:   cond_hit = direct;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_CNT_NZ:   cond_hit = (cnt_reg != '0);
            COND_OUT_BUSY: cond_hit = !out_free;
            default:       cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? uc.tgt_true : uc.tgt_false;
    end

    // operand selection for the current stage (tick count before increment)
    always_comb
    begin
        case (stage_reg)
            ST_ATTACK:  len_sel = sat_len(attack_reg);
            ST_DECAY:   len_sel = sat_len(decay_reg);
            ST_RELEASE: len_sel = sat_len(release_reg);
            default:    len_sel = '0;
        endcase
        remain     = (tick_reg >= len_sel) ? '0 : len_sel - tick_reg;
        mul_a      = remain;
        mul_b      = sustain_reg;
        offset     = '0;
        direct     = 1'b1;
        direct_val = '0;
        case (stage_reg)
            ST_ATTACK:
            begin
                // counter at or past the length saturates at full scale
                mul_a      = tick_reg;
                mul_b      = OUT_MAX;
                direct     = (tick_reg >= len_sel);
                direct_val = OUT_MAX;
            end
            ST_DECAY:
            begin
                mul_b      = OUT_MAX - sustain_reg;
                offset     = sustain_reg;
                direct     = (len_sel == '0);
                direct_val = sustain_reg;
            end
            ST_SUSTAIN:
            begin
                direct_val = sustain_reg;
            end
            ST_RELEASE:
            begin
                direct = (len_sel == '0);
            end
            default: ;
        endcase
    end

    // one quotient bit per cycle, remainder stays below the divisor
    assign trial = {rem_reg, num_reg[LVL_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign qbit  = (trial >= {1'b0, div_reg});

    assign stage_eff = (stage_reg > ST_RELEASE) ? ST_IDLE : stage_reg;

    always_comb
    begin
        stage_next     = stage_reg;
        gate_prev_next = gate_prev_reg;
        tick_next      = tick_reg;
        prod_next      = prod_reg;
        div_next       = div_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        level_next     = level_reg;
        phase_next     = phase_reg;

        case (uc.op)
            OP_ACCEPT:
            begin
                if (in_xfer)
                begin
                    gate_prev_next = gate;
                    if (gate && !gate_prev_reg)
                    begin
                        // rising edge restarts attack, even from release
                        stage_next = ST_ATTACK;
                        tick_next  = '0;
                    end
                    else if (!gate && gate_prev_reg)
                    begin
                        stage_next = ST_RELEASE;
                        tick_next  = '0;
                    end
                    else
                    begin
                        stage_next = stage_eff;
                    end
                end
            end
            OP_SETUP:
            begin
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
                div_next  = len_sel;
                base_next = direct ? direct_val : offset;
                quot_next = '0;
            end
            OP_DIV_INIT:
            begin
                rem_next = prod_reg[PROD_W-1:LVL_W];
                num_next = prod_reg[LVL_W-1:0];
                cnt_next = DIV_LAST;
            end
            OP_DIV_STEP:
            begin
                rem_next  = qbit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
                num_next  = {num_reg[LVL_W-2:0], 1'b0};
                quot_next = {quot_reg[LVL_W-2:0], qbit};
                cnt_next  = cnt_reg - 1'b1;
            end
            OP_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    level_next     = base_reg + quot_reg;
                    phase_next     = stage_reg;
                    // advance the counter or move on once it reaches the length
                    if (stage_reg inside {ST_ATTACK, ST_DECAY, ST_RELEASE})
                    begin
                        if (tick_reg >= div_reg)
                        begin
                            tick_next = '0;
                            case (stage_reg)
                                ST_ATTACK: stage_next = ST_DECAY;
                                ST_DECAY:  stage_next = ST_SUSTAIN;
                                default:   stage_next = ST_IDLE;
                            endcase
                        end
                        else
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            stage_reg     <= ST_IDLE;
            gate_prev_reg <= 1'b0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            stage_reg     <= stage_next;
            gate_prev_reg <= gate_prev_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        div_reg   <= div_next;
        base_reg  <= base_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        quot_reg  <= quot_next;
        level_reg <= level_next;
        phase_reg <= phase_next;
    end

    // an accepted tick always goes on to operand setup
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> step_reg == STEP_SETUP)
        else $error("accepted tick did not enter setup");

    // a full output register holds the sequencer in commit
    a_commit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_COMMIT && out_valid && !out_ready
        |=> step_reg == STEP_COMMIT && out_valid)
        else $error("commit overran a waiting result");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_DIV |-> rem_reg < div_reg)
        else $error("divider remainder out of range");

    // reported stage is a defined stage
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase <= ST_RELEASE)
        else $error("result carries an undefined stage");

endmodule
